// File: hdl/nearest_palette_color_classifier_unit_macros.svh
// Assertion macros for the nearest palette color classifier.
`ifndef NEAREST_PALETTE_COLOR_CLASSIFIER_UNIT_MACROS_SVH
`define NEAREST_PALETTE_COLOR_CLASSIFIER_UNIT_MACROS_SVH

`ifndef ASSERT_OFF
// Implication or plain property, checked on every rising clock edge out of reset.
`define NPC_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Condition that must never be seen out of reset.
`define NPC_ASSERT_NEVER(label, clk, rst_n, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define NPC_ASSERT(label, clk, rst_n, prop, msg)
`define NPC_ASSERT_NEVER(label, clk, rst_n, cond, msg)
`endif

`endif

// File: hdl/npc_pkg.sv
// Types and constants shared by the nearest palette color classifier.
`default_nettype none

package npc_pkg;

  localparam int unsigned CH_W       = 8;
  localparam int unsigned IDX_W      = 3;
  localparam int unsigned CNT_W      = 4;
  localparam int unsigned DIST_W     = 10;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 48;
  localparam int unsigned ENTRY_W    = 3 * CH_W;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LAYER_COUNT = 3'd0,
    REG_PAIR_A      = 3'd1,
    REG_PAIR_B      = 3'd2,
    REG_PAIR_C      = 3'd3,
    REG_PAIR_D      = 3'd4
  } cfg_reg_e;

  // One RGB color, red in the high byte.
  typedef struct packed {
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
  } rgb_t;

  // What one item carries from cell to cell.
  typedef struct packed {
    rgb_t              pix;
    logic              have_best;
    logic [DIST_W-1:0] best_dist;
    logic [IDX_W-1:0]  best_idx;
  } stage_t;

  // Absolute difference of two channel values.
  function automatic logic [CH_W-1:0] abs_diff(input logic [CH_W-1:0] a,
                                               input logic [CH_W-1:0] b);
    abs_diff = (a > b) ? (a - b) : (b - a);
  endfunction

endpackage

`default_nettype wire

// File: hdl/npc_ifs.sv
// Valid/ready channel interfaces for pixels in and palette indexes out.
`default_nettype none

interface npc_pix_if;
  import npc_pkg::*;

  logic            valid;
  logic            ready;
  logic [CH_W-1:0] pixel_red;
  logic [CH_W-1:0] pixel_green;
  logic [CH_W-1:0] pixel_blue;

  modport source (output valid, output pixel_red, output pixel_green,
                  output pixel_blue, input ready);
  modport sink   (input valid, input pixel_red, input pixel_green,
                  input pixel_blue, output ready);
endinterface

interface npc_cls_if;
  import npc_pkg::*;

  logic             valid;
  logic             ready;
  logic [IDX_W-1:0] layer_index;

  modport source (output valid, output layer_index, input ready);
  modport sink   (input valid, input layer_index, output ready);
endinterface

`default_nettype wire

// File: hdl/npc_cell.sv
// One cell of the classifier chain: compares the item with one palette entry.
`default_nettype none

module npc_cell (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       active_i,
  input  wire npc_pkg::rgb_t              entry_i,
  input  wire logic [npc_pkg::IDX_W-1:0]  idx_i,
  input  wire logic                       up_valid_i,
  output logic                            up_ready_o,
  input  wire npc_pkg::stage_t            up_data_i,
  output logic                            dn_valid_o,
  input  wire logic                       dn_ready_i,
  output npc_pkg::stage_t                 dn_data_o
);
  import npc_pkg::*;

  logic              valid_q, valid_d;
  stage_t            data_q, data_d;
  logic [DIST_W-1:0] l1_dist;
  logic              take;
  logic              load;

  // L1 distance from the item's pixel to this cell's entry.
  assign l1_dist = DIST_W'(abs_diff(entry_i.red,   up_data_i.pix.red))
                 + DIST_W'(abs_diff(entry_i.green, up_data_i.pix.green))
                 + DIST_W'(abs_diff(entry_i.blue,  up_data_i.pix.blue));

  // A later entry wins only when strictly nearer.
  assign take = active_i && (!up_data_i.have_best || (l1_dist < up_data_i.best_dist));

  // The cell takes an item when empty or when its own item moves on.
  assign up_ready_o = !valid_q || dn_ready_i;
  assign load       = up_valid_i && up_ready_o;

  always_comb begin
    data_d = up_data_i;
    if (take) begin
      data_d.have_best = 1'b1;
      data_d.best_dist = l1_dist;
      data_d.best_idx  = idx_i;
    end
  end

  always_comb begin
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
    end else if (dn_ready_i) begin
      valid_d = 1'b0;
    end
  end

  // Control register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Payload register.
  always_ff @(posedge clk_i) begin
    if (load) begin
      data_q <= data_d;
    end
  end

  assign dn_valid_o = valid_q;
  assign dn_data_o  = data_q;

endmodule

`default_nettype wire

// File: hdl/nearest_palette_color_classifier_unit.sv
// Top level of the nearest palette color classifier (L1 distance).
//
// Pixels arrive on pix_i, one item per cycle at most; each item yields one
// palette index on cls_o, the active entry with the smallest sum of absolute
// red, green and blue differences, the lowest index winning a tie.
// The work runs through a chain of MAX_LAYERS cells, one per palette entry;
// each cell compares the item with its entry and passes the best so far on.
// Each accepted item passes through every cell register in turn to cls_o; the chain
// sustains one item per cycle, set by the one-entry cell stage, while cls_o.ready is high.
// Each cell holds one item and takes a new one whenever it is empty or its
// item moves on, so a stalled receiver only halts the chain as it fills up:
// up to MAX_LAYERS items are taken before pix_i.ready falls.
// The configuration port writes layer_count and the palette pairs; the user must write it only
// while no item is in flight; the block does not enforce this. A layer_count of zero yields index 0.
// Reset empties the chain, sets layer_count to 1 and every entry to black.
`default_nettype none
`include "nearest_palette_color_classifier_unit_macros.svh"

module nearest_palette_color_classifier_unit #(
  parameter int unsigned MAX_LAYERS = 8
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            cfg_we_i,
  input  wire logic [npc_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  wire logic [npc_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  npc_pix_if.sink                              pix_i,
  npc_cls_if.source                            cls_o
);
  import npc_pkg::*;

  logic [CNT_W-1:0] layer_count_q;
  logic [CNT_W-1:0] count_sat;
  rgb_t             palette_q [MAX_LAYERS];
  logic             active [MAX_LAYERS];

  logic             st_valid [MAX_LAYERS+1];
  logic             st_ready [MAX_LAYERS+1];
  stage_t           st_data  [MAX_LAYERS+1];

  // Layer count register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      layer_count_q <= CNT_W'(1);
    end else if (cfg_we_i && (cfg_idx_i == REG_LAYER_COUNT)) begin
      layer_count_q <= cfg_data_i[CNT_W-1:0];
    end
  end

  // Counts above the chain length are clamped.
  assign count_sat = (layer_count_q > CNT_W'(MAX_LAYERS)) ? CNT_W'(MAX_LAYERS)
                                                          : layer_count_q;

  // Palette entries, two per pair register; entries past the chain are dropped.
  for (genvar e = 0; e < MAX_LAYERS; e++) begin : g_entry
    localparam logic [CFG_IDX_W-1:0] PairIdx = CFG_IDX_W'(REG_PAIR_A) + CFG_IDX_W'(e / 2);
    localparam int unsigned          Lsb     = (e % 2) * ENTRY_W;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        palette_q[e] <= '0;
      end else if (cfg_we_i && (cfg_idx_i == PairIdx)) begin
        palette_q[e] <= cfg_data_i[Lsb +: ENTRY_W];
      end
    end

    assign active[e] = (CNT_W'(e) < count_sat);
  end

  // Items enter the chain with no best entry yet.
  assign st_valid[0]          = pix_i.valid;
  assign pix_i.ready          = st_ready[0];
  assign st_data[0].pix.red   = pix_i.pixel_red;
  assign st_data[0].pix.green = pix_i.pixel_green;
  assign st_data[0].pix.blue  = pix_i.pixel_blue;
  assign st_data[0].have_best = 1'b0;
  assign st_data[0].best_dist = '0;
  assign st_data[0].best_idx  = '0;

  // The chain of cells, one per palette entry.
  for (genvar c = 0; c < MAX_LAYERS; c++) begin : g_cell
    npc_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .active_i   (active[c]),
      .entry_i    (palette_q[c]),
      .idx_i      (IDX_W'(c)),
      .up_valid_i (st_valid[c]),
      .up_ready_o (st_ready[c]),
      .up_data_i  (st_data[c]),
      .dn_valid_o (st_valid[c+1]),
      .dn_ready_i (st_ready[c+1]),
      .dn_data_o  (st_data[c+1])
    );
  end

  // The last cell's register drives the result channel.
  assign cls_o.valid          = st_valid[MAX_LAYERS];
  assign st_ready[MAX_LAYERS] = cls_o.ready;
  assign cls_o.layer_index    = st_data[MAX_LAYERS].best_idx;

  // Checks.
  `NPC_ASSERT(a_idx_in_range, clk_i, rst_ni, (cls_o.valid && (count_sat != '0)) |-> (CNT_W'(cls_o.layer_index) < count_sat), "result index beyond active entries")
  `NPC_ASSERT(a_empty_palette, clk_i, rst_ni, (cls_o.valid && (count_sat == '0)) |-> (cls_o.layer_index == '0), "nonzero index with no active entries")
  `NPC_ASSERT(a_enter_chain, clk_i, rst_ni, (pix_i.valid && pix_i.ready) |=> st_valid[1], "accepted item missing from first cell")
  `NPC_ASSERT_NEVER(a_best_missing, clk_i, rst_ni, cls_o.valid && (count_sat != '0) && !st_data[MAX_LAYERS].have_best, "no best entry recorded for result")

endmodule

`default_nettype wire
